// ===== rtl/core/fpr_pkg.sv =====
// Shared types, codes and helpers for the passive reply line parser.
// Used by fpr_char_update, fpr_line_judge and ftp_passive_reply_parser.
package fpr_pkg;

  localparam int FieldCount = 6;
  localparam int FsW        = $clog2(FieldCount + 1);
  localparam int CfgIdxW    = 1;

  localparam logic [7:0] ChOpen  = 8'h28;  // '('
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] FieldMax = 8'hFF;

  localparam logic [CfgIdxW-1:0] CfgPeerAddr = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAllowAny = 1'b1;

  typedef enum logic [1:0] {
    PhSeek    = 2'd0,
    PhCollect = 2'd1,
    PhDone    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    StAccepted  = 2'd0,
    StMalformed = 2'd1,
    StRefused   = 2'd2
  } status_e;

  typedef struct packed {
    phase_e                     phase;
    logic [FsW-1:0]             fs;
    logic [7:0]                 acc;
    logic                       dp;
    logic [FieldCount-1:0][7:0] fv;
  } line_state_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] addr;
    logic [15:0] port;
  } line_result_t;

  localparam line_state_t LineReset = '{
    phase: PhSeek,
    fs:    '0,
    acc:   '0,
    dp:    1'b0,
    fv:    '0
  };

  // store the accumulator as the next field; finish once all fields are held
  function automatic line_state_t store_field(line_state_t s);
    line_state_t r;
    r = s;
    for (int i = 0; i < FieldCount; i++) begin
      if (s.fs == FsW'(i)) begin
        r.fv[i] = s.acc;
      end
    end
    if (s.fs < FsW'(FieldCount)) begin
      r.fs = s.fs + FsW'(1);
    end
    r.acc = '0;
    r.dp  = 1'b0;
    if (r.fs >= FsW'(FieldCount)) begin
      r.phase = PhDone;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ftp_passive_reply_parser.sv =====
// Top level of the passive reply line parser: input register, parse state,
// result register and configuration. Depends on fpr_pkg, fpr_char_update,
// fpr_line_judge.
//
// One character enters per cycle. Each accepted word sits in an input
// register; a combinational update of the parse state (one
// multiply-by-ten, saturate and store) runs from that register, and on the
// marked last character the verdict is written to the result register. A
// result passes from the input register through the update and judgment into
// the result register. Input only stalls when a last character waits while
// the result register still holds an untaken result; a character that is not
// the last never holds up the input register.
module ftp_passive_reply_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] data_address, [47:32] port_number
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  input  logic        cfg_we_i,
  input  logic [fpr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);
  import fpr_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_char_q;
  logic         in_last_q;
  logic         out_valid_q;
  line_result_t out_q;
  logic [31:0]  peer_addr_q;
  logic         allow_any_q;
  line_state_t  state_q;
  line_state_t  state_d;
  line_result_t result_d;
  logic         advance;
  logic         out_free;

  fpr_char_update u_update (
    .state_i (state_q),
    .char_i  (in_char_q),
    .state_o (state_d)
  );

  fpr_line_judge u_judge (
    .state_i     (state_d),
    .peer_addr_i (peer_addr_q),
    .allow_any_i (allow_any_q),
    .result_o    (result_d)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LineReset;
    end else if (advance) begin
      state_q <= in_last_q ? LineReset : state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_addr_q <= '0;
      allow_any_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPeerAddr: peer_addr_q <= cfg_wdata_i;
        CfgAllowAny: allow_any_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.port, out_q.addr};
  assign m_axis_tuser_o  = out_q.status;

  a_reject_zero_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != StAccepted) |-> (m_axis_tdata_o == '0))
    else $error("non-accepted result carries address or port");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3))
    else $error("result status out of range");

  a_collect_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PhCollect) |-> (state_q.fs < FsW'(FieldCount)))
    else $error("collecting with all fields stored");

  a_line_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (state_q.phase == PhSeek && state_q.fs == '0
                                && !state_q.dp && state_q.acc == '0))
    else $error("parse state not cleared after line end");

endmodule

// ===== rtl/core/fpr_char_update.sv =====
// Per-character update of the line parse state.
// Depends on fpr_pkg (state type, character codes, store_field).
module fpr_char_update (
  input  fpr_pkg::line_state_t state_i,
  input  logic [7:0]           char_i,
  output fpr_pkg::line_state_t state_o
);
  import fpr_pkg::*;

  logic        is_digit;
  logic [11:0] mac;
  line_state_t stored;

  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  // acc * 10 + digit
  assign mac = {1'b0, state_i.acc, 3'b000} + {3'b000, state_i.acc, 1'b0}
             + {8'h00, char_i[3:0]};
  assign stored = store_field(state_i);

  always_comb begin
    state_o = state_i;
    unique case (state_i.phase)
      PhSeek: begin
        if (char_i == ChNul) begin
          state_o.phase = PhDone;
        end else if (char_i == ChOpen) begin
          state_o.phase = PhCollect;
        end
      end
      PhCollect: begin
        if (is_digit) begin
          state_o.acc = (mac > {4'h0, FieldMax}) ? FieldMax : mac[7:0];
          state_o.dp  = 1'b1;
        end else if (char_i == ChNul) begin
          if (state_i.dp) begin
            state_o = stored;
          end
          state_o.phase = PhDone;
        end else if (char_i == ChComma) begin
          state_o = stored;
        end else begin
          // remaining fields already hold zero
          state_o       = stored;
          state_o.fs    = FsW'(FieldCount);
          state_o.phase = PhDone;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ===== rtl/core/fpr_line_judge.sv =====
// End-of-line judgment: flush pending digits, check field count and peer.
// Depends on fpr_pkg (state and result types, status codes, store_field).
module fpr_line_judge (
  input  fpr_pkg::line_state_t  state_i,
  input  logic [31:0]           peer_addr_i,
  input  logic                  allow_any_i,
  output fpr_pkg::line_result_t result_o
);
  import fpr_pkg::*;

  line_state_t fin;
  logic [31:0] addr;
  logic        complete;
  logic        mismatch;

  assign fin = (state_i.phase == PhCollect && state_i.dp) ? store_field(state_i) : state_i;
  assign addr     = {fin.fv[0], fin.fv[1], fin.fv[2], fin.fv[3]};
  assign complete = fin.fs >= FsW'(FieldCount);
  assign mismatch = !allow_any_i && (peer_addr_i != '0) && (addr != peer_addr_i);

  always_comb begin
    result_o = '{status: StMalformed, addr: '0, port: '0};
    if (complete) begin
      if (mismatch) begin
        result_o.status = StRefused;
      end else begin
        result_o.status = StAccepted;
        result_o.addr   = addr;
        result_o.port   = {fin.fv[4], fin.fv[5]};
      end
    end
  end

endmodule

// ===== verif/tb_ftp_passive_reply_parser.sv =====
// Self-checking testbench for ftp_passive_reply_parser: feeds reply lines a word at a time
// and checks every verdict word against a behavioral line predictor or a typed row's want.
// Depends on fpr_pkg and the ftp_passive_reply_parser RTL.
`timescale 1ns / 100ps

module tb_ftp_passive_reply_parser;
  import fpr_pkg::*;

  typedef struct packed {
    logic [7:0]   ch;
    logic         last;
    logic         typed;
    line_result_t want;
  } dir_row_t;

  localparam line_result_t BadLine  = '{StMalformed, 32'd0, 16'd0};
  localparam line_result_t NullPair = '{StAccepted, 32'd0, 16'd0};
  localparam logic [7:0]   ChClose  = 8'h29;
  localparam logic [7:0]   ChDot    = 8'h2E;
  localparam int           NumDir   = 21;

  localparam dir_row_t DirRows [NumDir] = '{
    '{8'hFF,   1'b1, 1'b1, BadLine},
    '{ChNul,   1'b1, 1'b1, BadLine},
    '{ChOpen,  1'b1, 1'b1, BadLine},
    '{ChOpen,  1'b0, 1'b0, BadLine},
    '{ChClose, 1'b1, 1'b1, NullPair},
    '{ChOpen,  1'b0, 1'b0, BadLine},
    '{ChNine,  1'b0, 1'b0, BadLine},
    '{ChNine,  1'b0, 1'b0, BadLine},
    '{ChNine,  1'b1, 1'b1, BadLine},
    '{ChOpen,  1'b0, 1'b0, BadLine},
    '{8'h37,   1'b0, 1'b0, BadLine},
    '{ChNul,   1'b0, 1'b0, BadLine},
    '{8'h78,   1'b1, 1'b1, BadLine},
    '{ChOpen,  1'b0, 1'b0, BadLine},
    '{ChComma, 1'b0, 1'b0, BadLine},
    '{ChComma, 1'b0, 1'b0, BadLine},
    '{ChComma, 1'b0, 1'b0, BadLine},
    '{ChComma, 1'b0, 1'b0, BadLine},
    '{ChComma, 1'b0, 1'b0, BadLine},
    '{ChComma, 1'b0, 1'b0, BadLine},
    '{8'h37,   1'b1, 1'b0, BadLine}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  // line predictor state and its copy of the registers
  phase_e      pasv_phase;
  int          pasv_nfields;
  int          pasv_acc;
  bit          pasv_pending;
  logic [7:0]  pasv_fields [FieldCount];
  logic [31:0] peer_reg;
  logic        allow_any_reg;

  line_result_t replies_due [$];
  logic [7:0]   line_chars [$];
  int           mismatches;
  int           items_sent;
  bit           tx_calm;

  ftp_passive_reply_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic void pasv_clear();
    pasv_phase   = PhSeek;
    pasv_nfields = 0;
    pasv_acc     = 0;
    pasv_pending = 1'b0;
    for (int i = 0; i < FieldCount; i++) pasv_fields[i] = 8'd0;
  endfunction

  function automatic void pasv_store_field();
    if (pasv_nfields < FieldCount) begin
      pasv_fields[pasv_nfields] = pasv_acc[7:0];
      pasv_nfields++;
    end
    pasv_acc     = 0;
    pasv_pending = 1'b0;
    if (pasv_nfields >= FieldCount) pasv_phase = PhDone;
  endfunction

  // advance the line state by one word; returns 1 with the verdict on the last word
  function automatic bit pasv_take_char(input logic [7:0] c, input logic last,
                                        output line_result_t res);
    logic [31:0] addr;
    res = BadLine;
    case (pasv_phase)
      PhSeek: begin
        if (c == ChNul) pasv_phase = PhDone;
        else if (c == ChOpen) pasv_phase = PhCollect;
      end
      PhCollect: begin
        if (c >= ChZero && c <= ChNine) begin
          pasv_acc = pasv_acc * 10 + int'(c - ChZero);
          if (pasv_acc > int'(FieldMax)) pasv_acc = int'(FieldMax);
          pasv_pending = 1'b1;
        end else if (c == ChNul) begin
          if (pasv_pending) pasv_store_field();
          pasv_phase = PhDone;
        end else if (c == ChComma) begin
          pasv_store_field();
        end else begin
          pasv_store_field();
          while (pasv_nfields < FieldCount) pasv_store_field();
        end
      end
      default: ;
    endcase
    if (!last) return 1'b0;
    if (pasv_phase == PhCollect && pasv_pending) pasv_store_field();
    if (pasv_nfields >= FieldCount) begin
      addr = {pasv_fields[0], pasv_fields[1], pasv_fields[2], pasv_fields[3]};
      if (!allow_any_reg && peer_reg != 32'd0 && addr != peer_reg) begin
        res.status = StRefused;
      end else begin
        res.status = StAccepted;
        res.addr   = addr;
        res.port   = {pasv_fields[4], pasv_fields[5]};
      end
    end
    pasv_clear();
    return 1'b1;
  endfunction

  function automatic void push_dec(input int v);
    if (v < 0) return;
    if ($urandom_range(0, 3) == 0) line_chars.push_back(ChZero);
    if (v >= 100) line_chars.push_back(ChZero + 8'(v / 100));
    if (v >= 10) line_chars.push_back(ChZero + 8'((v / 10) % 10));
    line_chars.push_back(ChZero + 8'(v % 10));
  endfunction

  // mostly well-formed replies with random content, some truncated, some noise
  function automatic void build_line();
    int kind;
    int nfld;
    int v;
    bit copy_peer;
    logic [7:0] b;
    line_chars.delete();
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0:       b = ChOpen;
          1:       b = ChComma;
          2:       b = ChZero + 8'($urandom_range(0, 9));
          default: b = 8'($urandom_range(0, 255));
        endcase
        line_chars.push_back(b);
      end
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      do b = 8'($urandom_range(1, 255)); while (b == ChOpen);
      line_chars.push_back(b);
    end
    line_chars.push_back(ChOpen);
    nfld = (kind == 7) ? $urandom_range(0, 5) : FieldCount;
    copy_peer = (peer_reg != 32'd0) && ($urandom_range(0, 1) == 1);
    for (int f = 0; f < nfld; f++) begin
      if (f > 0) line_chars.push_back(ChComma);
      if (copy_peer && f < 4) begin
        v = int'(peer_reg[31 - 8 * f -: 8]);
      end else begin
        case ($urandom_range(0, 9))
          0:       v = -1;
          1:       v = $urandom_range(256, 999);
          default: v = $urandom_range(0, 255);
        endcase
      end
      push_dec(v);
    end
    case ($urandom_range(0, 3))
      0: line_chars.push_back(ChClose);
      1: ;
      2: line_chars.push_back(ChNul);
      default: begin
        line_chars.push_back(ChClose);
        line_chars.push_back(ChDot);
      end
    endcase
    if (kind == 7 && $urandom_range(0, 1) == 1) begin
      line_chars.insert($urandom_range(0, line_chars.size() - 1), ChNul);
    end
    repeat ($urandom_range(0, 2)) line_chars.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic push_char(input logic [7:0] c, input logic last, input logic typed,
                           input line_result_t want);
    line_result_t res;
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
    if (pasv_take_char(c, last, res)) replies_due.push_back(typed ? want : res);
  endtask

  task automatic send_line();
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < line_chars.size(); i++) begin
      push_char(line_chars[i], i == line_chars.size() - 1, 1'b0, BadLine);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [31:0] peer, input logic allow);
    cfg_we    <= 1'b1;
    cfg_index <= CfgPeerAddr;
    cfg_wdata <= peer;
    @(posedge clk_i);
    cfg_index <= CfgAllowAny;
    cfg_wdata <= {31'd0, allow};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    peer_reg      = peer;
    allow_any_reg = allow;
  endtask

  initial begin : stimulus
    logic [31:0] peers [4];
    logic        allows [4];
    int phase_start;
    int phase_lines;
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = 8'd0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CfgPeerAddr;
    cfg_wdata = 32'd0;
    mismatches    = 0;
    items_sent    = 0;
    tx_calm       = 1'b0;
    peer_reg      = 32'd0;
    allow_any_reg = 1'b0;
    pasv_clear();
    peers[0] = 32'hFFFF_FFFF;  allows[0] = 1'b0;
    peers[1] = $urandom();     allows[1] = 1'b1;
    peers[2] = $urandom();     allows[2] = 1'b0;
    peers[3] = 32'd0;          allows[3] = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDir; r++) begin
      push_char(DirRows[r].ch, DirRows[r].last, DirRows[r].typed, DirRows[r].want);
    end

    for (int p = 0; p < 4; p++) begin
      drain();
      apply_settings(peers[p], allows[p]);
      phase_start = items_sent;
      phase_lines = 0;
      while (items_sent - phase_start < 100 || phase_lines < 12) begin
        build_line();
        send_line();
        phase_lines++;
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ftp_passive_reply_parser regression: pass");
    end else begin
      $display("ftp_passive_reply_parser regression: fail");
    end
    $finish;
  end

  initial begin : reply_sink
    line_result_t want;
    int stall;
    bit calm;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 3) == 0) calm = ~calm;
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply word status=%0d addr=%h port=%h",
                 $realtime, m_tuser, m_tdata[31:0], m_tdata[47:32]);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (m_tuser != want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, m_tuser);
          mismatches++;
        end
        if (m_tdata[31:0] != want.addr) begin
          $display("%0t: data_address expected %h actual %h",
                   $realtime, want.addr, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[47:32] != want.port) begin
          $display("%0t: port_number expected %h actual %h",
                   $realtime, want.port, m_tdata[47:32]);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #400000;
    $display("ftp_passive_reply_parser regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fpr_pkg.sv
rtl/core/fpr_char_update.sv
rtl/core/fpr_line_judge.sv
rtl/core/ftp_passive_reply_parser.sv
verif/tb_ftp_passive_reply_parser.sv
